// File: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds through reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/rcc_pkg.sv
package rcc_pkg;

    localparam int ACC_W      = 24;
    localparam int LVL_W      = 8;
    localparam int K_W        = 16;
    localparam int DB_W       = 7;
    localparam int IDLE_W     = 9;
    localparam int SENS_W     = 6;
    localparam int BUZ_W      = 16;
    localparam int AUX_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [7:0] HDR_START    = 8'h20;
    localparam logic [7:0] HDR_LENGTH   = 8'h0f;
    localparam logic [7:0] KIND_PAD     = 8'h02;
    localparam logic [7:0] KIND_APP     = 8'h66;
    localparam logic [7:0] TRIG_HIGH    = 8'd250;
    localparam logic [7:0] TRIG_LOW     = 8'd10;
    localparam logic [7:0] STICK_CENTER = 8'h80;

    localparam logic [7:0] BTN_STAND = 8'd1;
    localparam logic [7:0] BTN_AUX   = 8'd2;
    localparam logic [7:0] BTN_SENS  = 8'd4;

    // smoothing coefficients, Q0.16
    localparam logic [K_W-1:0] K_HALF    = 16'd32768;
    localparam logic [K_W-1:0] K_QUARTER = 16'd16384;
    localparam logic [K_W-1:0] K_P8      = 16'd52429;
    localparam logic [K_W-1:0] K_P1      = 16'd6554;
    localparam logic [K_W-1:0] K_P01     = 16'd655;
    localparam logic [K_W-1:0] K_ROUND   = 16'hffff;

    localparam logic [SENS_W-1:0] SENS_PAD_MID = 6'd25;
    localparam logic [SENS_W-1:0] SENS_PAD_LO  = 6'd20;
    localparam logic [SENS_W-1:0] SENS_PAD_HI  = 6'd35;
    localparam logic [SENS_W-1:0] SENS_APP_MID = 6'd10;
    localparam logic [SENS_W-1:0] SENS_APP_LO  = 6'd8;
    localparam logic [SENS_W-1:0] SENS_APP_HI  = 6'd12;

    localparam logic [IDLE_W-1:0] IDLE_MAX  = 9'd511;
    localparam logic [IDLE_W-1:0] IDLE_HOLD = 9'd500;

    localparam logic [DB_W-1:0]   DEF_DB_PAD      = 7'd8;
    localparam logic [DB_W-1:0]   DEF_DB_APP_FWD  = 7'd5;
    localparam logic [DB_W-1:0]   DEF_DB_APP_TURN = 7'd25;
    localparam logic [IDLE_W-1:0] DEF_TIMEOUT     = 9'd150;
    localparam logic [SENS_W-1:0] DEF_SENS        = 6'd20;
    localparam logic [BUZ_W-1:0]  DEF_BUZZER      = 16'd200;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DB_PAD      = 3'd0,
        CFG_DB_APP_FWD  = 3'd1,
        CFG_DB_APP_TURN = 3'd2,
        CFG_TIMEOUT     = 3'd3,
        CFG_SENS_RESET  = 3'd4,
        CFG_BUZZER      = 3'd5
    } cfg_idx_e;

    typedef enum logic {
        REQ_FRAME = 1'b0,
        REQ_TICK  = 1'b1
    } req_type_e;

    typedef enum logic [1:0] {
        CH_HOLD  = 2'd0,
        CH_FRAME = 2'd1,
        CH_DECAY = 2'd2
    } ch_op_e;

    typedef struct packed {
        ch_op_e                  op;
        logic signed [LVL_W-1:0] c;
        logic [DB_W-1:0]         db;
        logic [K_W-1:0]          k_in;   // inside deadband, or decay
        logic [K_W-1:0]          k_out;  // outside deadband
        logic                    coarse; // wide snap window
    } ch_ctrl_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] hdr_start;
        logic [7:0] hdr_length;
        logic [7:0] frame_kind;
        logic [7:0] aux_byte;
        logic [7:0] stick_alt;
        logic [7:0] stick_fwd;
        logic [7:0] stick_turn;
        logic [7:0] button_code;
        logic [7:0] left_trigger;
        logic [7:0] right_trigger;
    } cmd_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] x_smooth;
        logic signed [ACC_W-1:0] z_smooth;
        logic                    x_active;
        logic                    z_active;
        logic                    protect;
        logic                    auto_stand;
        logic                    steer_mode;
        logic [AUX_W-1:0]        aux_value;
        logic [SENS_W-1:0]       sensitivity;
        logic [BUZ_W-1:0]        buzzer_level;
        logic                    cali_clear;
    } rsp_t;

endpackage

// File: rtl/core/rcc_stream_if.sv
interface rcc_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/rcc_channel.sv
module rcc_channel #(
    parameter int FRAC_BITS = 16
) (
    input  rcc_pkg::ch_ctrl_t                     ctrl,
    input  logic signed [rcc_pkg::ACC_W-1:0]      acc,
    input  logic signed [rcc_pkg::LVL_W-1:0]      lvl,
    input  logic                                  flag,
    output logic signed [rcc_pkg::ACC_W-1:0]      acc_next,
    output logic signed [rcc_pkg::LVL_W-1:0]      lvl_next,
    output logic                                  flag_next
);

    localparam int AW = rcc_pkg::ACC_W;
    localparam int LW = rcc_pkg::LVL_W;
    localparam int KW = rcc_pkg::K_W;
    localparam int TW = LW + FRAC_BITS;
    localparam int DW = ((TW > AW) ? TW : AW) + 1;
    localparam int PW = DW + KW;

    localparam int SNAP_FINE_I   = ((1 << FRAC_BITS) + 9999) / 10000;
    localparam int SNAP_COARSE_I = ((1 << FRAC_BITS) + 999) / 1000;

    localparam logic signed [AW-1:0] SNAP_FINE       = AW'(SNAP_FINE_I);
    localparam logic signed [AW-1:0] SNAP_FINE_NEG   = AW'(-SNAP_FINE_I);
    localparam logic signed [AW-1:0] SNAP_COARSE     = AW'(SNAP_COARSE_I);
    localparam logic signed [AW-1:0] SNAP_COARSE_NEG = AW'(-SNAP_COARSE_I);

    localparam logic signed [DW:0] SAT_HI = (DW+1)'((1 << (AW - 1)) - 1);
    localparam logic signed [DW:0] SAT_LO = ~SAT_HI;

    logic signed [LW:0]   c_w;
    logic signed [LW:0]   db_w;
    logic signed [LW:0]   lvl_w;
    logic [LW:0]          c_abs;
    logic signed [LW-1:0] tgt;
    logic [KW-1:0]        k;
    logic                 do_smooth;
    logic                 do_snap;
    logic                 set_flag;

    logic signed [DW-1:0] tgt_fix;
    logic signed [DW-1:0] acc_w;
    logic signed [DW-1:0] diff;
    logic [DW-1:0]        mag;
    logic [PW-1:0]        prod;
    logic [DW-1:0]        step;
    logic signed [DW:0]   sum;
    logic signed [AW-1:0] acc_sm;
    logic signed [AW-1:0] lim_hi;
    logic signed [AW-1:0] lim_lo;

    // deadband decision and target level
    always_comb
    begin
        c_w       = {ctrl.c[LW-1], ctrl.c};
        db_w      = signed'({{(LW + 1 - rcc_pkg::DB_W){1'b0}}, ctrl.db});
        c_abs     = c_w[LW] ? unsigned'(-c_w) : unsigned'(c_w);
        lvl_w     = '0;
        lvl_next  = lvl;
        tgt       = lvl;
        k         = ctrl.k_in;
        do_smooth = 1'b0;
        do_snap   = 1'b0;
        set_flag  = 1'b0;
        case (ctrl.op)
            rcc_pkg::CH_FRAME:
            begin
                if (c_abs < unsigned'(db_w))
                begin
                    lvl_next  = '0;
                    tgt       = '0;
                    do_smooth = 1'b1;
                    do_snap   = 1'b1;
                end
                else if (c_w > db_w)
                begin
                    lvl_w     = c_w - db_w;
                    lvl_next  = lvl_w[LW-1:0];
                    tgt       = lvl_w[LW-1:0];
                    k         = ctrl.k_out;
                    do_smooth = 1'b1;
                    set_flag  = 1'b1;
                end
                else if (c_w < -db_w)
                begin
                    lvl_w     = c_w + db_w;
                    lvl_next  = lvl_w[LW-1:0];
                    tgt       = lvl_w[LW-1:0];
                    k         = ctrl.k_out;
                    do_smooth = 1'b1;
                    set_flag  = 1'b1;
                end
                else
                begin
                    // exactly on the deadband edge: level only
                    lvl_next = ctrl.c;
                end
            end
            rcc_pkg::CH_DECAY:
            begin
                if (lvl > 0)
                begin
                    lvl_next = lvl - LW'(1);
                end
                else if (lvl < 0)
                begin
                    lvl_next = lvl + LW'(1);
                end
                tgt       = lvl_next;
                do_smooth = 1'b1;
                do_snap   = 1'b1;
            end
            default:
            begin
                lvl_next = lvl;
            end
        endcase
    end

    // acc moves by ceil(|diff| * k / 2^16) toward the target, then saturates
    always_comb
    begin
        tgt_fix = signed'({{(DW - LW){tgt[LW-1]}}, tgt} << FRAC_BITS);
        acc_w   = {{(DW - AW){acc[AW-1]}}, acc};
        diff    = tgt_fix - acc_w;
        mag     = diff[DW-1] ? unsigned'(-diff) : unsigned'(diff);
        prod    = {{KW{1'b0}}, mag} * {{DW{1'b0}}, k} + PW'(rcc_pkg::K_ROUND);
        step    = prod[PW-1:KW];
        if (diff[DW-1])
        begin
            sum = {acc_w[DW-1], acc_w} - signed'({1'b0, step});
        end
        else
        begin
            sum = {acc_w[DW-1], acc_w} + signed'({1'b0, step});
        end
        if (sum > SAT_HI)
        begin
            acc_sm = SAT_HI[AW-1:0];
        end
        else if (sum < SAT_LO)
        begin
            acc_sm = SAT_LO[AW-1:0];
        end
        else
        begin
            acc_sm = sum[AW-1:0];
        end
    end

    always_comb
    begin
        lim_hi    = ctrl.coarse ? SNAP_COARSE : SNAP_FINE;
        lim_lo    = ctrl.coarse ? SNAP_COARSE_NEG : SNAP_FINE_NEG;
        acc_next  = acc;
        flag_next = flag;
        if (do_smooth)
        begin
            acc_next = acc_sm;
        end
        if (set_flag)
        begin
            flag_next = 1'b1;
        end
        if (do_snap && acc_sm < lim_hi && acc_sm > lim_lo)
        begin
            acc_next  = '0;
            flag_next = 1'b0;
        end
    end

endmodule

// File: rtl/core/rc_command_conditioner_top.sv
// Remote command conditioner. Each word on cmd is a received 15-byte frame or an idle
// tick, and each gives exactly one word on rsp carrying the conditioned stick channels
// (signed, FRAC_BITS fraction bits) and the mode, aux, sensitivity, buzzer and protect
// state after that word. A word is registered on entry and its result lands in the
// result register when rsp is free. One word is taken every cycle unless a result
// waits on rsp with the input stage full. The per-cycle limit is the state update
// loop: deadband, one coefficient multiply per channel and saturation, all fed back
// into the channel accumulators in the same cycle. Configuration is written through
// cfg_we, cfg_index and cfg_data while no word is in flight; sensitivity_reset writes
// have no effect, as sensitivity resets to its default. No clearing pass after reset.
module rc_command_conditioner_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rcc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rcc_pkg::CFG_DATA_W-1:0]    cfg_data,
    rcc_stream_if.sink                        cmd,
    rcc_stream_if.source                      rsp
);

    localparam int AW = rcc_pkg::ACC_W;
    localparam int LW = rcc_pkg::LVL_W;

    // configuration
    logic [rcc_pkg::DB_W-1:0]   db_pad_reg;
    logic [rcc_pkg::DB_W-1:0]   db_app_fwd_reg;
    logic [rcc_pkg::DB_W-1:0]   db_app_turn_reg;
    logic [rcc_pkg::IDLE_W-1:0] timeout_reg;
    logic [rcc_pkg::BUZ_W-1:0]  buz_cmp_reg;

    // input stage and handshake
    rcc_pkg::cmd_t stg_reg;
    logic          stg_valid_reg;
    logic          rsp_valid_reg;
    logic          advance;
    logic          commit;

    // block state
    logic signed [AW-1:0]        x_acc_reg, x_acc_next;
    logic signed [AW-1:0]        z_acc_reg, z_acc_next;
    logic signed [LW-1:0]        fwd_lvl_reg, fwd_lvl_next;
    logic signed [LW-1:0]        turn_lvl_reg, turn_lvl_next;
    logic                        x_flag_reg, x_flag_next;
    logic                        z_flag_reg, z_flag_next;
    logic                        mode_reg, mode_next;
    logic                        latch_reg, latch_next;
    logic                        aux_armed_reg, aux_armed_next;
    logic                        sens_armed_reg, sens_armed_next;
    logic [rcc_pkg::AUX_W-1:0]   aux_reg, aux_next;
    logic                        protect_reg, protect_next;
    logic                        stand_reg, stand_next;
    logic [rcc_pkg::SENS_W-1:0]  sens_reg, sens_next;
    logic [rcc_pkg::IDLE_W-1:0]  idle_reg, idle_next;
    logic [rcc_pkg::BUZ_W-1:0]   buzzer_reg, buzzer_next;
    logic                        cali_reg, cali_next;

    rcc_pkg::ch_ctrl_t           x_ctrl;
    rcc_pkg::ch_ctrl_t           z_ctrl;
    logic                        hdr_ok;
    logic [rcc_pkg::IDLE_W-1:0]  idle_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            db_pad_reg      <= rcc_pkg::DEF_DB_PAD;
            db_app_fwd_reg  <= rcc_pkg::DEF_DB_APP_FWD;
            db_app_turn_reg <= rcc_pkg::DEF_DB_APP_TURN;
            timeout_reg     <= rcc_pkg::DEF_TIMEOUT;
            buz_cmp_reg     <= rcc_pkg::DEF_BUZZER;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rcc_pkg::CFG_DB_PAD:      db_pad_reg      <= cfg_data[rcc_pkg::DB_W-1:0];
                rcc_pkg::CFG_DB_APP_FWD:  db_app_fwd_reg  <= cfg_data[rcc_pkg::DB_W-1:0];
                rcc_pkg::CFG_DB_APP_TURN: db_app_turn_reg <= cfg_data[rcc_pkg::DB_W-1:0];
                rcc_pkg::CFG_TIMEOUT:     timeout_reg     <= cfg_data[rcc_pkg::IDLE_W-1:0];
                rcc_pkg::CFG_BUZZER:      buz_cmp_reg     <= cfg_data[rcc_pkg::BUZ_W-1:0];
                // reset restores the default before the value could ever be used
                rcc_pkg::CFG_SENS_RESET:  buz_cmp_reg     <= buz_cmp_reg;
                default:                  buz_cmp_reg     <= buz_cmp_reg;
            endcase
        end
    end

    assign advance   = !rsp_valid_reg || rsp.ready;
    assign commit    = stg_valid_reg && advance;
    assign cmd.ready = !stg_valid_reg || advance;

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            stg_reg <= cmd.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                stg_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                stg_valid_reg <= 1'b0;
            end
            if (stg_valid_reg)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        hdr_ok   = stg_reg.hdr_start == rcc_pkg::HDR_START
                   && stg_reg.hdr_length == rcc_pkg::HDR_LENGTH;
        idle_inc = (idle_reg < rcc_pkg::IDLE_MAX) ? idle_reg + 1'b1 : idle_reg;

        mode_next       = mode_reg;
        latch_next      = latch_reg;
        aux_armed_next  = aux_armed_reg;
        sens_armed_next = sens_armed_reg;
        aux_next        = aux_reg;
        protect_next    = protect_reg;
        stand_next      = stand_reg;
        sens_next       = sens_reg;
        idle_next       = idle_reg;
        buzzer_next     = buzzer_reg;
        cali_next       = 1'b0;

        x_ctrl.op     = rcc_pkg::CH_HOLD;
        x_ctrl.c      = '0;
        x_ctrl.db     = db_pad_reg;
        x_ctrl.k_in   = rcc_pkg::K_P01;
        x_ctrl.k_out  = rcc_pkg::K_P01;
        x_ctrl.coarse = 1'b0;
        z_ctrl.op     = rcc_pkg::CH_HOLD;
        z_ctrl.c      = '0;
        z_ctrl.db     = db_pad_reg;
        z_ctrl.k_in   = rcc_pkg::K_P1;
        z_ctrl.k_out  = rcc_pkg::K_P1;
        z_ctrl.coarse = 1'b0;

        if (stg_reg.req_type == rcc_pkg::REQ_FRAME)
        begin
            idle_next = '0;
            if (hdr_ok && stg_reg.frame_kind == rcc_pkg::KIND_PAD)
            begin
                if (stg_reg.left_trigger > rcc_pkg::TRIG_HIGH)
                begin
                    protect_next = 1'b1;
                    stand_next   = 1'b0;
                end
                if (stg_reg.right_trigger > rcc_pkg::TRIG_HIGH && !latch_reg)
                begin
                    latch_next = 1'b1;
                    mode_next  = !mode_reg;
                end
                else if (stg_reg.right_trigger < rcc_pkg::TRIG_LOW)
                begin
                    latch_next = 1'b0;
                end

                // button edges: press arms, release fires
                if (stg_reg.button_code == rcc_pkg::BTN_AUX && !aux_armed_reg)
                begin
                    aux_armed_next = 1'b1;
                end
                else if (stg_reg.button_code != rcc_pkg::BTN_AUX && aux_armed_reg)
                begin
                    aux_armed_next = 1'b0;
                    if (aux_reg == 8'd0)
                    begin
                        aux_next = 8'd1;
                    end
                    else if (aux_reg == 8'd1)
                    begin
                        aux_next = 8'd0;
                    end
                end
                else if (stg_reg.button_code == rcc_pkg::BTN_SENS && !sens_armed_reg)
                begin
                    sens_armed_next = 1'b1;
                end
                else if (stg_reg.button_code != rcc_pkg::BTN_SENS && sens_armed_reg)
                begin
                    sens_armed_next = 1'b0;
                    if (sens_reg < rcc_pkg::SENS_PAD_MID)
                    begin
                        sens_next = rcc_pkg::SENS_PAD_HI;
                    end
                    else if (sens_reg > rcc_pkg::SENS_PAD_MID)
                    begin
                        sens_next = rcc_pkg::SENS_PAD_LO;
                    end
                end
                else if (stg_reg.button_code == rcc_pkg::BTN_STAND)
                begin
                    buzzer_next = buz_cmp_reg;
                    stand_next  = 1'b1;
                end
                else
                begin
                    buzzer_next = '0;
                end

                // gamepad sticks are offset binary
                x_ctrl.op     = rcc_pkg::CH_FRAME;
                x_ctrl.c      = signed'(stg_reg.stick_fwd ^ rcc_pkg::STICK_CENTER);
                x_ctrl.db     = db_pad_reg;
                x_ctrl.k_in   = rcc_pkg::K_HALF;
                x_ctrl.k_out  = rcc_pkg::K_QUARTER;
                x_ctrl.coarse = 1'b0;
                z_ctrl.op     = rcc_pkg::CH_FRAME;
                z_ctrl.c      = mode_next
                                ? signed'(stg_reg.stick_alt ^ rcc_pkg::STICK_CENTER)
                                : signed'(stg_reg.stick_turn ^ rcc_pkg::STICK_CENTER);
                z_ctrl.db     = db_pad_reg;
                z_ctrl.k_in   = rcc_pkg::K_P8;
                z_ctrl.k_out  = rcc_pkg::K_P1;
                z_ctrl.coarse = 1'b0;
            end
            else if (hdr_ok && stg_reg.frame_kind == rcc_pkg::KIND_APP)
            begin
                aux_next = stg_reg.aux_byte;
                if (stg_reg.button_code == rcc_pkg::BTN_AUX && !aux_armed_reg)
                begin
                    aux_armed_next = 1'b1;
                end
                else if (stg_reg.button_code != rcc_pkg::BTN_AUX && aux_armed_reg)
                begin
                    aux_armed_next = 1'b0;
                end
                else if (stg_reg.button_code == rcc_pkg::BTN_SENS && !sens_armed_reg)
                begin
                    sens_armed_next = 1'b1;
                end
                else if (stg_reg.button_code != rcc_pkg::BTN_SENS && sens_armed_reg)
                begin
                    sens_armed_next = 1'b0;
                    if (sens_reg < rcc_pkg::SENS_APP_MID)
                    begin
                        sens_next = rcc_pkg::SENS_APP_HI;
                    end
                    else if (sens_reg > rcc_pkg::SENS_APP_MID)
                    begin
                        sens_next = rcc_pkg::SENS_APP_LO;
                    end
                end
                else if (stg_reg.button_code == rcc_pkg::BTN_STAND)
                begin
                    buzzer_next = buz_cmp_reg;
                    if (protect_reg)
                    begin
                        protect_next = 1'b0;
                        cali_next    = 1'b1;
                    end
                end
                else
                begin
                    buzzer_next = '0;
                end

                // app bytes are two's complement; forward and turn are swapped
                x_ctrl.op     = rcc_pkg::CH_FRAME;
                x_ctrl.c      = signed'(stg_reg.stick_turn);
                x_ctrl.db     = db_app_fwd_reg;
                x_ctrl.k_in   = rcc_pkg::K_P1;
                x_ctrl.k_out  = rcc_pkg::K_HALF;
                x_ctrl.coarse = 1'b1;
                z_ctrl.op     = rcc_pkg::CH_FRAME;
                z_ctrl.c      = signed'(stg_reg.stick_fwd);
                z_ctrl.db     = db_app_turn_reg;
                z_ctrl.k_in   = rcc_pkg::K_P1;
                z_ctrl.k_out  = rcc_pkg::K_HALF;
                z_ctrl.coarse = 1'b1;
            end
        end
        else
        begin
            idle_next = idle_inc;
            if (idle_inc >= timeout_reg)
            begin
                idle_next = rcc_pkg::IDLE_HOLD;
                x_ctrl.op = rcc_pkg::CH_DECAY;
                z_ctrl.op = rcc_pkg::CH_DECAY;
            end
        end
    end

    rcc_channel #(.FRAC_BITS(FRAC_BITS)) u_x_ch (
        .ctrl      (x_ctrl),
        .acc       (x_acc_reg),
        .lvl       (fwd_lvl_reg),
        .flag      (x_flag_reg),
        .acc_next  (x_acc_next),
        .lvl_next  (fwd_lvl_next),
        .flag_next (x_flag_next)
    );

    rcc_channel #(.FRAC_BITS(FRAC_BITS)) u_z_ch (
        .ctrl      (z_ctrl),
        .acc       (z_acc_reg),
        .lvl       (turn_lvl_reg),
        .flag      (z_flag_reg),
        .acc_next  (z_acc_next),
        .lvl_next  (turn_lvl_next),
        .flag_next (z_flag_next)
    );

    // state only moves when the result slot can take the word, so the
    // state registers double as the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_acc_reg      <= '0;
            z_acc_reg      <= '0;
            fwd_lvl_reg    <= '0;
            turn_lvl_reg   <= '0;
            x_flag_reg     <= 1'b0;
            z_flag_reg     <= 1'b0;
            mode_reg       <= 1'b0;
            latch_reg      <= 1'b0;
            aux_armed_reg  <= 1'b0;
            sens_armed_reg <= 1'b0;
            aux_reg        <= '0;
            protect_reg    <= 1'b0;
            stand_reg      <= 1'b0;
            sens_reg       <= rcc_pkg::DEF_SENS;
            idle_reg       <= '0;
            buzzer_reg     <= '0;
            cali_reg       <= 1'b0;
        end
        else if (commit)
        begin
            x_acc_reg      <= x_acc_next;
            z_acc_reg      <= z_acc_next;
            fwd_lvl_reg    <= fwd_lvl_next;
            turn_lvl_reg   <= turn_lvl_next;
            x_flag_reg     <= x_flag_next;
            z_flag_reg     <= z_flag_next;
            mode_reg       <= mode_next;
            latch_reg      <= latch_next;
            aux_armed_reg  <= aux_armed_next;
            sens_armed_reg <= sens_armed_next;
            aux_reg        <= aux_next;
            protect_reg    <= protect_next;
            stand_reg      <= stand_next;
            sens_reg       <= sens_next;
            idle_reg       <= idle_next;
            buzzer_reg     <= buzzer_next;
            cali_reg       <= cali_next;
        end
    end

    assign rsp.valid             = rsp_valid_reg;
    assign rsp.data.x_smooth     = x_acc_reg;
    assign rsp.data.z_smooth     = z_acc_reg;
    assign rsp.data.x_active     = x_flag_reg;
    assign rsp.data.z_active     = z_flag_reg;
    assign rsp.data.protect      = protect_reg;
    assign rsp.data.auto_stand   = stand_reg;
    assign rsp.data.steer_mode   = mode_reg;
    assign rsp.data.aux_value    = aux_reg;
    assign rsp.data.sensitivity  = sens_reg;
    assign rsp.data.buzzer_level = buzzer_reg;
    assign rsp.data.cali_clear   = cali_reg;

endmodule

// File: rtl/core/rcc_checker.sv
`include "assert_macros.svh"

module rcc_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          cmd_valid,
    input logic          cmd_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input rcc_pkg::rsp_t rsp_data
);

    // a stalled result word holds still
    `ASSERT_CLK(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "rsp word changed while stalled")

    // clearing calibration always drops the protect flag in the same word
    `ASSERT_CLK(a_cali_protect, clk, rst_n, rsp_valid && rsp_data.cali_clear |-> !rsp_data.protect, "cali_clear with protect still set")

    // protect must be set again before another clear, so no two clears in a row
    `ASSERT_CLK(a_cali_twice, clk, rst_n, rsp_valid && rsp_ready && rsp_data.cali_clear |=> !(rsp_valid && rsp_data.cali_clear), "cali_clear on consecutive words")

    // sensitivity only ever toggles among its default and the toggle targets
    `ASSERT_CLK(a_sens_set, clk, rst_n, rsp_valid |-> rsp_data.sensitivity == rcc_pkg::DEF_SENS || rsp_data.sensitivity == rcc_pkg::SENS_PAD_HI || rsp_data.sensitivity == rcc_pkg::SENS_APP_LO || rsp_data.sensitivity == rcc_pkg::SENS_APP_HI, "sensitivity outside toggle set")

    // input side stays open while the result side is free
    `ASSERT_CLK(a_cmd_open, clk, rst_n, !rsp_valid |-> cmd_ready, "cmd stalled with empty result slot")

endmodule

bind rc_command_conditioner_top rcc_checker u_rcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

// File: bench/rc_command_conditioner_top_tb.sv
`timescale 1ns / 1ps

module rc_command_conditioner_top_tb;

    import rcc_pkg::*;

    localparam int     FRAC        = 16;
    localparam int     SNAP_FINE   = ((1 << FRAC) + 9999) / 10000;
    localparam int     SNAP_COARSE = ((1 << FRAC) + 999) / 1000;
    localparam longint ACC_HI      = 64'sd8388607;
    localparam longint ACC_LO      = -64'sd8388608;
    localparam int     STUCK_LIMIT = 3000;

    localparam logic [7:0] BTN_NONE = 8'd0;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rcc_stream_if #(.T(cmd_t)) cmd_if ();
    rcc_stream_if #(.T(rsp_t)) rsp_if ();

    rc_command_conditioner_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_if),
        .rsp       (rsp_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // register mirror
    logic [DB_W-1:0]   db_pad   = DEF_DB_PAD;
    logic [DB_W-1:0]   db_fwd   = DEF_DB_APP_FWD;
    logic [DB_W-1:0]   db_turn  = DEF_DB_APP_TURN;
    logic [IDLE_W-1:0] tmo      = DEF_TIMEOUT;
    logic [SENS_W-1:0] sens_rst = DEF_SENS;
    logic [BUZ_W-1:0]  buz_cmp  = DEF_BUZZER;

    // conditioner state
    logic signed [15:0]      fwd_lvl      = '0;
    logic signed [15:0]      turn_lvl     = '0;
    logic signed [ACC_W-1:0] x_acc        = '0;
    logic signed [ACC_W-1:0] z_acc        = '0;
    logic                    x_on         = 1'b0;
    logic                    z_on         = 1'b0;
    logic                    mode         = 1'b0;
    logic                    trig_latched = 1'b0;
    logic                    aux_armed    = 1'b0;
    logic                    sens_armed   = 1'b0;
    logic [AUX_W-1:0]        aux          = '0;
    logic                    prot_on      = 1'b0;
    logic                    stand        = 1'b0;
    logic [SENS_W-1:0]       sens         = DEF_SENS;
    logic [IDLE_W-1:0]       idle_cnt     = '0;
    logic [BUZ_W-1:0]        buzzer       = '0;

    rsp_t conditioned_q[$];
    int   mismatches   = 0;
    int   rsp_count    = 0;
    int   stuck_cycles = 0;
    int   hold_left    = 0;
    bit   src_steady   = 1'b0;
    bit   src_no_gaps  = 1'b0;
    bit   sink_steady  = 1'b0;

    function automatic logic signed [ACC_W-1:0] smooth_step(input logic signed [ACC_W-1:0] acc,
                                                            input int target,
                                                            input logic [K_W-1:0] k);
        longint diff;
        longint mag;
        longint delta;
        longint res;
        diff = (longint'(target) <<< FRAC) - longint'(acc);
        mag = diff < 0 ? -diff : diff;
        // ceil of mag * k / 2^16, so the step never stalls short of the target
        delta = (mag * longint'(k) + longint'(K_ROUND)) >>> 16;
        res = diff < 0 ? longint'(acc) - delta : longint'(acc) + delta;
        if (res > ACC_HI)
            res = ACC_HI;
        if (res < ACC_LO)
            res = ACC_LO;
        return res[ACC_W-1:0];
    endfunction

    function automatic logic signed [15:0] ease_to_zero(input logic signed [15:0] v);
        if (v > 0)
            return v - 16'sd1;
        if (v < 0)
            return v + 16'sd1;
        return '0;
    endfunction

    task automatic snap_zero(inout logic signed [ACC_W-1:0] acc, inout logic on, input int lim);
        if (acc < lim && acc > -lim)
        begin
            acc = '0;
            on = 1'b0;
        end
    endtask

    task automatic run_channel(input int c, input int db, input logic [K_W-1:0] k_in,
                               input logic [K_W-1:0] k_out, input int lim,
                               inout logic signed [15:0] lvl,
                               inout logic signed [ACC_W-1:0] acc, inout logic on);
        int mag;
        mag = c < 0 ? -c : c;
        if (mag < db)
        begin
            lvl = '0;
            acc = smooth_step(acc, 0, k_in);
            snap_zero(acc, on, lim);
        end
        else if (c > db)
        begin
            lvl = c - db;
            acc = smooth_step(acc, lvl, k_out);
            on = 1'b1;
        end
        else if (c < -db)
        begin
            lvl = c + db;
            acc = smooth_step(acc, lvl, k_out);
            on = 1'b1;
        end
        else
            lvl = c;  // right at the deadband edge: level only
    endtask

    task automatic condition_cmd(input cmd_t w, output rsp_t r);
        int   cz;
        logic cali;
        logic hdr_ok;
        cali = 1'b0;
        hdr_ok = w.hdr_start == HDR_START && w.hdr_length == HDR_LENGTH;
        if (w.req_type == REQ_FRAME)
        begin
            idle_cnt = '0;
            if (hdr_ok && w.frame_kind == KIND_PAD)
            begin
                if (w.left_trigger > TRIG_HIGH)
                begin
                    prot_on = 1'b1;
                    stand = 1'b0;
                end
                if (w.right_trigger > TRIG_HIGH && !trig_latched)
                begin
                    trig_latched = 1'b1;
                    mode = ~mode;
                end
                else if (w.right_trigger < TRIG_LOW)
                    trig_latched = 1'b0;
                cz = mode ? int'(w.stick_alt) - int'(STICK_CENTER)
                          : int'(w.stick_turn) - int'(STICK_CENTER);
                if (w.button_code == BTN_AUX && !aux_armed)
                    aux_armed = 1'b1;
                else if (w.button_code != BTN_AUX && aux_armed)
                begin
                    aux_armed = 1'b0;
                    if (aux == 8'd0)
                        aux = 8'd1;
                    else if (aux == 8'd1)
                        aux = 8'd0;
                end
                else if (w.button_code == BTN_SENS && !sens_armed)
                    sens_armed = 1'b1;
                else if (w.button_code != BTN_SENS && sens_armed)
                begin
                    sens_armed = 1'b0;
                    if (sens < SENS_PAD_MID)
                        sens = SENS_PAD_HI;
                    else if (sens > SENS_PAD_MID)
                        sens = SENS_PAD_LO;
                end
                else if (w.button_code == BTN_STAND)
                begin
                    buzzer = buz_cmp;
                    stand = 1'b1;
                end
                else
                    buzzer = '0;
                run_channel(int'(w.stick_fwd) - int'(STICK_CENTER), db_pad, K_HALF, K_QUARTER,
                            SNAP_FINE, fwd_lvl, x_acc, x_on);
                run_channel(cz, db_pad, K_P8, K_P1, SNAP_FINE, turn_lvl, z_acc, z_on);
            end
            else if (hdr_ok && w.frame_kind == KIND_APP)
            begin
                aux = w.aux_byte;
                if (w.button_code == BTN_AUX && !aux_armed)
                    aux_armed = 1'b1;
                else if (w.button_code != BTN_AUX && aux_armed)
                    aux_armed = 1'b0;
                else if (w.button_code == BTN_SENS && !sens_armed)
                    sens_armed = 1'b1;
                else if (w.button_code != BTN_SENS && sens_armed)
                begin
                    sens_armed = 1'b0;
                    if (sens < SENS_APP_MID)
                        sens = SENS_APP_HI;
                    else if (sens > SENS_APP_MID)
                        sens = SENS_APP_LO;
                end
                else if (w.button_code == BTN_STAND)
                begin
                    buzzer = buz_cmp;
                    if (prot_on)
                    begin
                        prot_on = 1'b0;
                        cali = 1'b1;
                    end
                end
                else
                    buzzer = '0;
                // app frames swap the stick bytes and carry signed values
                run_channel(int'($signed(w.stick_turn)), db_fwd, K_P1, K_HALF, SNAP_COARSE,
                            fwd_lvl, x_acc, x_on);
                run_channel(int'($signed(w.stick_fwd)), db_turn, K_P1, K_HALF, SNAP_COARSE,
                            turn_lvl, z_acc, z_on);
            end
        end
        else
        begin
            if (idle_cnt < IDLE_MAX)
                idle_cnt++;
            if (idle_cnt >= tmo)
            begin
                idle_cnt = IDLE_HOLD;
                fwd_lvl = ease_to_zero(fwd_lvl);
                x_acc = smooth_step(x_acc, fwd_lvl, K_P01);
                snap_zero(x_acc, x_on, SNAP_FINE);
                turn_lvl = ease_to_zero(turn_lvl);
                z_acc = smooth_step(z_acc, turn_lvl, K_P1);
                snap_zero(z_acc, z_on, SNAP_FINE);
            end
        end
        r.x_smooth = x_acc;
        r.z_smooth = z_acc;
        r.x_active = x_on;
        r.z_active = z_on;
        r.protect = prot_on;
        r.auto_stand = stand;
        r.steer_mode = mode;
        r.aux_value = aux;
        r.sensitivity = sens;
        r.buzzer_level = buzzer;
        r.cali_clear = cali;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic cmd_t raw_word(input req_type_e kind);
        cmd_t w;
        w.req_type = kind;
        w.hdr_start = rand_byte();
        w.hdr_length = rand_byte();
        w.frame_kind = rand_byte();
        w.aux_byte = rand_byte();
        w.stick_alt = rand_byte();
        w.stick_fwd = rand_byte();
        w.stick_turn = rand_byte();
        w.button_code = rand_byte();
        w.left_trigger = rand_byte();
        w.right_trigger = rand_byte();
        return w;
    endfunction

    function automatic cmd_t pad_frame(input logic [7:0] fwd, input logic [7:0] turn,
                                       input logic [7:0] alt, input logic [7:0] btn,
                                       input logic [7:0] lt, input logic [7:0] rt);
        cmd_t w;
        w = raw_word(REQ_FRAME);
        w.hdr_start = HDR_START;
        w.hdr_length = HDR_LENGTH;
        w.frame_kind = KIND_PAD;
        w.stick_fwd = fwd;
        w.stick_turn = turn;
        w.stick_alt = alt;
        w.button_code = btn;
        w.left_trigger = lt;
        w.right_trigger = rt;
        return w;
    endfunction

    // x rides in stick_turn and z in stick_fwd on app frames
    function automatic cmd_t app_frame(input logic [7:0] aux_b, input logic [7:0] x_b,
                                       input logic [7:0] z_b, input logic [7:0] btn);
        cmd_t w;
        w = raw_word(REQ_FRAME);
        w.hdr_start = HDR_START;
        w.hdr_length = HDR_LENGTH;
        w.frame_kind = KIND_APP;
        w.aux_byte = aux_b;
        w.stick_turn = x_b;
        w.stick_fwd = z_b;
        w.button_code = btn;
        return w;
    endfunction

    // center 128 for gamepad bytes, 0 for signed app bytes
    function automatic logic [7:0] pick_stick(input int center, input int db);
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return rand_byte();
        if (r < 80)
            return 8'(center + int'($urandom_range(0, 2 * (db + 2))) - (db + 2));
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'h7F;
            2: return 8'h80;
            default: return 8'hFF;
        endcase
    endfunction

    function automatic logic [7:0] pick_button();
        case ($urandom_range(0, 6))
            0, 1: return BTN_NONE;
            2: return BTN_STAND;
            3: return BTN_AUX;
            4: return BTN_SENS;
            default: return $urandom_range(0, 3) == 0 ? rand_byte() : BTN_NONE;
        endcase
    endfunction

    function automatic logic [7:0] pick_trigger();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return rand_byte();
        if (r < 7)
            return 8'($urandom_range(251, 255));
        return 8'($urandom_range(0, 9));
    endfunction

    task automatic send_word(input cmd_t w);
        rsp_t want;
        int   gap;
        if ($urandom_range(0, 31) == 0)
            src_steady = !src_steady;
        gap = (src_steady || src_no_gaps) ? 0 : pick_gap();
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data <= w;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        condition_cmd(w, want);
        conditioned_q.push_back(want);
    endtask

    task automatic drain();
        cmd_if.valid <= 1'b0;
        while (conditioned_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_DB_PAD:      db_pad = val[DB_W-1:0];
            CFG_DB_APP_FWD:  db_fwd = val[DB_W-1:0];
            CFG_DB_APP_TURN: db_turn = val[DB_W-1:0];
            CFG_TIMEOUT:     tmo = val[IDLE_W-1:0];
            CFG_SENS_RESET:  sens_rst = val[SENS_W-1:0];  // no effect: the DUT ignores it
            CFG_BUZZER:      buz_cmp = val[BUZ_W-1:0];
            default: ;
        endcase
    endtask

    // only called with nothing in flight
    task automatic load_config(input logic [DB_W-1:0] pad_v, input logic [DB_W-1:0] fwd_v,
                               input logic [DB_W-1:0] turn_v, input logic [IDLE_W-1:0] tmo_v,
                               input logic [SENS_W-1:0] sens_v, input logic [BUZ_W-1:0] buz_v);
        write_reg(CFG_DB_PAD, pad_v);
        write_reg(CFG_DB_APP_FWD, fwd_v);
        write_reg(CFG_DB_APP_TURN, turn_v);
        write_reg(CFG_TIMEOUT, tmo_v);
        write_reg(CFG_SENS_RESET, sens_v);
        write_reg(CFG_BUZZER, buz_v);
        cfg_we <= 1'b0;
    endtask

    task automatic test_pad_controls();
        send_word(pad_frame(8'hFF, 8'h00, 8'h80, BTN_NONE, 8'd0, 8'd0));
        send_word(pad_frame(8'h00, 8'hFF, 8'h80, BTN_AUX, 8'd0, 8'd0));
        // exactly on the deadband edge; aux toggles on release
        send_word(pad_frame(8'd136, 8'd120, 8'h80, BTN_NONE, 8'd0, 8'd0));
        send_word(pad_frame(8'd130, 8'd125, 8'h80, BTN_SENS, 8'd0, 8'd0));
        send_word(pad_frame(8'h80, 8'h80, 8'h80, BTN_NONE, 8'd0, 8'd255));
        send_word(pad_frame(8'd200, 8'd100, 8'hFF, BTN_NONE, 8'd0, 8'd255));
        send_word(pad_frame(8'd200, 8'd100, 8'h00, BTN_NONE, 8'd0, 8'd5));
        send_word(pad_frame(8'h80, 8'h80, 8'h80, BTN_STAND, 8'd0, 8'd0));
        send_word(pad_frame(8'd60, 8'd190, 8'h80, BTN_STAND, 8'd255, 8'd0));
        send_word(pad_frame(8'h80, 8'h80, 8'h80, BTN_NONE, 8'd251, 8'd251));
    endtask

    task automatic test_app_controls();
        // protect is set here, so the stand button clears it with a cali pulse
        send_word(app_frame(8'h00, 8'h7F, 8'h80, BTN_STAND));
        send_word(app_frame(8'hFF, 8'd5, 8'(-25), BTN_STAND));
        send_word(app_frame(8'h01, 8'd3, 8'(-3), BTN_SENS));
        send_word(app_frame(8'h01, 8'h00, 8'h00, BTN_NONE));
        send_word(app_frame(8'h00, 8'h80, 8'h7F, BTN_AUX));
        send_word(app_frame(8'h00, 8'h81, 8'h7E, BTN_NONE));
    endtask

    task automatic test_header_checks();
        cmd_t w;
        w = pad_frame(8'hFF, 8'hFF, 8'hFF, BTN_STAND, 8'd255, 8'd255);
        w.hdr_start = 8'h21;
        send_word(w);
        w = app_frame(8'h55, 8'h7F, 8'h7F, BTN_STAND);
        w.hdr_length = 8'h0e;
        send_word(w);
        w = pad_frame(8'h00, 8'h00, 8'h00, BTN_AUX, 8'd255, 8'd255);
        w.frame_kind = 8'h03;
        send_word(w);
        send_word(raw_word(REQ_TICK));
        drain();
    endtask

    task automatic test_idle_decay();
        load_config(DEF_DB_PAD, DEF_DB_APP_FWD, DEF_DB_APP_TURN, 9'd1, DEF_SENS, DEF_BUZZER);
        repeat (3) send_word(pad_frame(8'hFF, 8'h00, 8'h00, BTN_NONE, 8'd0, 8'd0));
        repeat (40) send_word(raw_word(REQ_TICK));
        send_word(app_frame(8'h00, 8'h80, 8'h7F, BTN_NONE));
        repeat (30) send_word(raw_word(REQ_TICK));
        drain();
        // timeout at IDLE_HOLD: the counter reaches it and holds there while decaying
        load_config(DEF_DB_PAD, DEF_DB_APP_FWD, DEF_DB_APP_TURN, 9'd500, DEF_SENS, DEF_BUZZER);
        send_word(pad_frame(8'h00, 8'hFF, 8'hFF, BTN_NONE, 8'd0, 8'd0));
        repeat (510) send_word(raw_word(REQ_TICK));
        drain();
    endtask

    task automatic test_random_traffic(input int count);
        cmd_t w;
        int   sent;
        int   r;
        int   run;
        sent = 0;
        while (sent < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 2)
            begin
                // tick burst long enough to cross the timeout now and then
                run = $urandom_range(1, int'(tmo) + 20);
                repeat (run) send_word(raw_word(REQ_TICK));
                sent += run;
            end
            else
            begin
                if (r < 42)
                    w = pad_frame(pick_stick(128, db_pad), pick_stick(128, db_pad),
                                  pick_stick(128, db_pad), pick_button(), pick_trigger(),
                                  pick_trigger());
                else if (r < 67)
                    w = app_frame($urandom_range(0, 2) == 0 ? 8'($urandom_range(0, 1))
                                                             : rand_byte(),
                                  pick_stick(0, db_fwd), pick_stick(0, db_turn), pick_button());
                else if (r < 88)
                    w = raw_word(REQ_TICK);
                else
                begin
                    w = raw_word(REQ_FRAME);
                    case ($urandom_range(0, 2))
                        0:
                        begin
                            w.hdr_length = HDR_LENGTH;
                            w.frame_kind = $urandom_range(0, 1) ? KIND_PAD : KIND_APP;
                        end
                        1:
                        begin
                            w.hdr_start = HDR_START;
                            w.frame_kind = $urandom_range(0, 1) ? KIND_PAD : KIND_APP;
                        end
                        default:
                        begin
                            w.hdr_start = HDR_START;
                            w.hdr_length = HDR_LENGTH;
                        end
                    endcase
                end
                send_word(w);
                sent++;
            end
        end
        drain();
    endtask

    task automatic test_backpressure();
        hold_left = 200;
        src_no_gaps = 1'b1;
        repeat (50) send_word(pad_frame(pick_stick(128, db_pad), pick_stick(128, db_pad),
                                        pick_stick(128, db_pad), pick_button(),
                                        pick_trigger(), pick_trigger()));
        src_no_gaps = 1'b0;
        drain();
    endtask

    initial
    begin
        cmd_if.valid = 1'b0;
        cmd_if.data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pad_controls();
        test_app_controls();
        test_header_checks();
        test_idle_decay();
        load_config(DEF_DB_PAD, DEF_DB_APP_FWD, DEF_DB_APP_TURN, DEF_TIMEOUT, DEF_SENS,
                    DEF_BUZZER);
        test_random_traffic(330);
        test_backpressure();
        load_config(7'd0, 7'd0, 7'd0, 9'd1, 6'd63, 16'hFFFF);
        test_random_traffic(330);
        load_config(7'd64, 7'd64, 7'd64, 9'd500, 6'd0, 16'h0000);
        test_random_traffic(330);
        load_config(7'($urandom_range(0, 64)), 7'($urandom_range(0, 64)),
                    7'($urandom_range(0, 64)), 9'($urandom_range(2, 60)),
                    6'($urandom_range(0, 63)), 16'($urandom_range(0, 65535)));
        test_random_traffic(330);

        if (mismatches == 0 && conditioned_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // result side: random stalls plus the long hold asked by the backpressure test
    initial
    begin
        int stall;
        stall = 0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end
            else if (stall > 0)
            begin
                rsp_if.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                if ($urandom_range(0, 31) == 0)
                    sink_steady = !sink_steady;
                stall = sink_steady ? 0 : pick_gap();
            end
        end
    end

    task automatic check_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
        if (want !== got)
        begin
            if (mismatches < 10)
                $display("word %0d %s: expected %0h, got %0h", rsp_count, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        rsp_t got;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got = rsp_if.data;
            if (conditioned_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("word %0d: result with no prediction pending", rsp_count);
                mismatches++;
            end
            else
            begin
                want = conditioned_q.pop_front();
                check_field("x_smooth", want.x_smooth, got.x_smooth);
                check_field("z_smooth", want.z_smooth, got.z_smooth);
                check_field("x_active", want.x_active, got.x_active);
                check_field("z_active", want.z_active, got.z_active);
                check_field("protect", want.protect, got.protect);
                check_field("auto_stand", want.auto_stand, got.auto_stand);
                check_field("steer_mode", want.steer_mode, got.steer_mode);
                check_field("aux_value", want.aux_value, got.aux_value);
                check_field("sensitivity", want.sensitivity, got.sensitivity);
                check_field("buzzer_level", want.buzzer_level, got.buzzer_level);
                check_field("cali_clear", want.cali_clear, got.cali_clear);
            end
            rsp_count++;
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/rcc_pkg.sv
rtl/core/rcc_stream_if.sv
rtl/core/rcc_channel.sv
rtl/core/rc_command_conditioner_top.sv
rtl/core/rcc_checker.sv
bench/rc_command_conditioner_top_tb.sv
